[design/sim_pkg.sv]
// Shared types and codes for the sorted insert and merge block.
package sim_pkg;

  // Request operation codes.
  localparam logic [1:0] OP_INS_A = 2'd0;
  localparam logic [1:0] OP_INS_B = 2'd1;
  localparam logic [1:0] OP_MERGE = 2'd2;

  // Result kind codes.
  localparam logic [1:0] KIND_OK    = 2'd0;
  localparam logic [1:0] KIND_FULL  = 2'd1;
  localparam logic [1:0] KIND_ENTRY = 2'd2;
  localparam logic [1:0] KIND_EMPTY = 2'd3;

  // Control handed from the sequencer to one list and its cells.
  typedef struct packed {
    logic ins;  // insert the new value at its sorted place
    logic rot;  // move every entry one place toward the head, head to tail
  } sim_ctl_t;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE  = 2'b01,
    ST_MERGE = 2'b10
  } sim_state_t;

endpackage

[design/sim_cell.sv]
// One storage cell of a sorted list chain.
module sim_cell
  import sim_pkg::*;
#(
  parameter int VW = 32
) (
  input  logic                 clk,
  input  sim_ctl_t             ctl,
  input  logic                 occ,        // this cell holds a live entry
  input  logic                 tail,       // this cell is the last live entry
  input  logic                 prev_lt,    // left neighbour stays in place on insert
  input  logic signed [VW-1:0] new_value,
  input  logic signed [VW-1:0] left_value,
  input  logic signed [VW-1:0] right_value,
  input  logic signed [VW-1:0] head_value,
  output logic signed [VW-1:0] value,
  output logic                 lt          // this entry stays in place on insert
);

  logic signed [VW-1:0] value_r;
  logic signed [VW-1:0] value_nxt;

  // A live entry strictly below the new value keeps its place.
  assign lt    = occ && (value_r < new_value);
  assign value = value_r;

  // Select the next content: keep, take the new value, shift or rotate.
  always_comb begin
    value_nxt = value_r;
    if (ctl.ins) begin
      if (lt) begin
        value_nxt = value_r;
      end else if (prev_lt) begin
        value_nxt = new_value;
      end else begin
        value_nxt = left_value;
      end
    end else if (ctl.rot) begin
      value_nxt = tail ? head_value : right_value;
    end
  end

  // Entry storage carries no reset.
  always_ff @(posedge clk) begin
    value_r <= value_nxt;
  end

endmodule

[design/sim_list.sv]
// One bounded ascending list built as a chain of cells with its fill count.
module sim_list
  import sim_pkg::*;
#(
  parameter int DEPTH = 32,
  parameter int VW    = 32
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  sim_ctl_t                             ctl,
  input  logic signed [VW-1:0]                 new_value,
  output logic signed [VW-1:0]                 head,
  output logic [$clog2(DEPTH+1)-1:0]           count,
  output logic                                 full
);

  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [CNT_W-1:0]     count_r;
  logic [CNT_W-1:0]     count_nxt;
  logic signed [VW-1:0] cell_value [DEPTH];
  logic                 cell_lt    [DEPTH];
  logic                 cell_occ   [DEPTH];
  logic                 cell_tail  [DEPTH];

  assign head  = cell_value[0];
  assign count = count_r;
  assign full  = (count_r == CNT_W'(DEPTH));

  // Per-cell occupancy and tail flags from the fill count.
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      cell_occ[i]  = (CNT_W'(i) < count_r);
      cell_tail[i] = (CNT_W'(i + 1) == count_r);
    end
  end

  // The chain of cells; each one sees its two neighbours.
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic                 prev_lt;
    logic signed [VW-1:0] left_value;
    logic signed [VW-1:0] right_value;

    if (g == 0) begin : g_first
      assign prev_lt    = 1'b1;
      assign left_value = new_value;
    end else begin : g_inner
      assign prev_lt    = cell_lt[g-1];
      assign left_value = cell_value[g-1];
    end

    if (g == DEPTH - 1) begin : g_last
      assign right_value = cell_value[0];
    end else begin : g_mid
      assign right_value = cell_value[g+1];
    end

    sim_cell #(
      .VW (VW)
    ) u_cell (
      .clk         (clk),
      .ctl         (ctl),
      .occ         (cell_occ[g]),
      .tail        (cell_tail[g]),
      .prev_lt     (prev_lt),
      .new_value   (new_value),
      .left_value  (left_value),
      .right_value (right_value),
      .head_value  (cell_value[0]),
      .value       (cell_value[g]),
      .lt          (cell_lt[g])
    );
  end

  // The fill count grows on each insert that fits.
  always_comb begin
    count_nxt = count_r;
    if (ctl.ins && !full) begin
      count_nxt = count_r + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

endmodule

[design/sorted_insert_and_merge.sv]
// Top level of the sorted insert and merge block: sequencer, two lists, output register.
//
//   Channel  Direction  Handshake            Payload
//   in       request    in_valid / in_stall  in_op, in_value
//   out      result     out_valid/out_stall  out_kind, out_entry, out_from_second, out_last
//
// An insert is done in the cycle it is accepted: every cell compares and shifts at once,
// so inserts run at one per cycle while the output register drains.
// A merge holds the input while it runs: it loads the entry counts first, then emits one
// entry per cycle while the output is free (just an empty result if both lists are empty);
// each list rotates one place per entry taken and is back in order when the merge ends.
// Reset empties both lists by clearing their fill counts; there is no clearing pass.
// A stalled output holds its request and stops the merge sequencer in place.
module sorted_insert_and_merge
  import sim_pkg::*;
#(
  parameter int LIST_DEPTH  = 32,
  parameter int VALUE_WIDTH = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_op,
  input  logic signed [31:0] in_value,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         out_kind,
  output logic signed [31:0] out_entry,
  output logic               out_from_second,
  output logic               out_last
);

  localparam int CNT_W = $clog2(LIST_DEPTH + 1);
  localparam int IO_W  = (VALUE_WIDTH < 32) ? VALUE_WIDTH : 32;

  sim_state_t st_r;
  sim_state_t st_nxt;

  logic [CNT_W-1:0] rem_a_r;
  logic [CNT_W-1:0] rem_a_nxt;
  logic [CNT_W-1:0] rem_b_r;
  logic [CNT_W-1:0] rem_b_nxt;

  logic               out_valid_r;
  logic               out_valid_nxt;
  logic [1:0]         out_kind_r;
  logic [1:0]         out_kind_nxt;
  logic signed [31:0] out_entry_r;
  logic signed [31:0] out_entry_nxt;
  logic               out_second_r;
  logic               out_second_nxt;
  logic               out_last_r;
  logic               out_last_nxt;

  sim_ctl_t ctl_a;
  sim_ctl_t ctl_b;

  logic signed [VALUE_WIDTH-1:0] new_value;
  logic signed [VALUE_WIDTH-1:0] head_a;
  logic signed [VALUE_WIDTH-1:0] head_b;
  logic [CNT_W-1:0]              count_a;
  logic [CNT_W-1:0]              count_b;
  logic                          full_a;
  logic                          full_b;

  logic out_free;
  logic in_fire;
  logic step;
  logic a_left;
  logic b_left;
  logic take_a;
  logic step_last;

  // The input value is read as its low bits, zero-extended into list width.
  assign new_value = VALUE_WIDTH'(in_value[IO_W-1:0]);

  // The output register can load when empty or being taken this cycle.
  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = (st_r != ST_IDLE) || !out_free;
  assign in_fire  = in_valid && !in_stall;

  // Merge selection: list A wins when B is drained or its head is strictly below B's; ties go to B.
  assign a_left    = (rem_a_r != '0);
  assign b_left    = (rem_b_r != '0);
  assign take_a    = a_left && (!b_left || (head_a < head_b));
  assign step      = (st_r == ST_MERGE) && out_free;
  assign step_last = take_a ? ((rem_a_r == CNT_W'(1)) && !b_left)
                            : ((rem_b_r == CNT_W'(1)) && !a_left);

  // Sequencer and output register loading.
  always_comb begin
    st_nxt         = st_r;
    rem_a_nxt      = rem_a_r;
    rem_b_nxt      = rem_b_r;
    ctl_a          = '0;
    ctl_b          = '0;
    out_valid_nxt  = out_valid_r && out_stall;
    out_kind_nxt   = out_kind_r;
    out_entry_nxt  = out_entry_r;
    out_second_nxt = out_second_r;
    out_last_nxt   = out_last_r;

    case (st_r)
      ST_IDLE: begin
        if (in_fire) begin
          case (in_op)
            OP_INS_A, OP_INS_B: begin
              ctl_a.ins      = (in_op == OP_INS_A) && !full_a;
              ctl_b.ins      = (in_op == OP_INS_B) && !full_b;
              out_valid_nxt  = 1'b1;
              out_kind_nxt   = ((in_op == OP_INS_A) ? full_a : full_b) ? KIND_FULL : KIND_OK;
              out_entry_nxt  = '0;
              out_second_nxt = 1'b0;
              out_last_nxt   = 1'b1;
            end
            OP_MERGE: begin
              if ((count_a == '0) && (count_b == '0)) begin
                out_valid_nxt  = 1'b1;
                out_kind_nxt   = KIND_EMPTY;
                out_entry_nxt  = '0;
                out_second_nxt = 1'b0;
                out_last_nxt   = 1'b1;
              end else begin
                rem_a_nxt = count_a;
                rem_b_nxt = count_b;
                st_nxt    = ST_MERGE;
              end
            end
            default: begin
              // Unused code: the request is taken and dropped.
            end
          endcase
        end
      end
      ST_MERGE: begin
        if (step) begin
          ctl_a.rot      = take_a;
          ctl_b.rot      = !take_a;
          out_valid_nxt  = 1'b1;
          out_kind_nxt   = KIND_ENTRY;
          out_entry_nxt  = 32'(take_a ? head_a[IO_W-1:0] : head_b[IO_W-1:0]);
          out_second_nxt = !take_a;
          out_last_nxt   = step_last;
          if (take_a) begin
            rem_a_nxt = rem_a_r - CNT_W'(1);
          end else begin
            rem_b_nxt = rem_b_r - CNT_W'(1);
          end
          if (step_last) begin
            st_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        st_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      rem_a_r     <= '0;
      rem_b_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      rem_a_r     <= rem_a_nxt;
      rem_b_r     <= rem_b_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result payload registers.
  always_ff @(posedge clk) begin
    out_kind_r   <= out_kind_nxt;
    out_entry_r  <= out_entry_nxt;
    out_second_r <= out_second_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_kind        = out_kind_r;
  assign out_entry       = out_entry_r;
  assign out_from_second = out_second_r;
  assign out_last        = out_last_r;

  // List A.
  sim_list #(
    .DEPTH (LIST_DEPTH),
    .VW    (VALUE_WIDTH)
  ) u_list_a (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl_a),
    .new_value (new_value),
    .head      (head_a),
    .count     (count_a),
    .full      (full_a)
  );

  // List B.
  sim_list #(
    .DEPTH (LIST_DEPTH),
    .VW    (VALUE_WIDTH)
  ) u_list_b (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl_b),
    .new_value (new_value),
    .head      (head_b),
    .count     (count_b),
    .full      (full_b)
  );

  // A merge in progress always has at least one entry left to emit.
  a_merge_not_dry : assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_MERGE) |-> (a_left || b_left))
    else $error("merge running with both lists drained");

  // Entries left to emit never exceed what a list holds.
  a_rem_bounded : assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_MERGE) |-> ((rem_a_r <= count_a) && (rem_b_r <= count_b)))
    else $error("merge remainder exceeds list fill");

  // The lists keep their fill during a merge.
  a_merge_keeps_fill : assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_MERGE) |=> ($stable(count_a) && $stable(count_b)))
    else $error("list fill changed during merge");

  // The final merged entry returns the sequencer to idle.
  a_last_ends_merge : assert property (@(posedge clk) disable iff (!rst_n)
    (step && step_last) |=> (st_r == ST_IDLE) && out_valid && out_last)
    else $error("merge did not end on its last entry");

endmodule

[dv/testbench.sv]
// Self-checking testbench for the sorted insert and merge block.
`timescale 1ns / 100ps

module testbench
  import sim_pkg::*;
();

  localparam int          LIST_DEPTH      = 32;
  localparam int          RANDOM_REQUESTS = 360;
  localparam int          HOLD_CYCLES     = 160;
  localparam int          DRAIN_CYCLES    = 12;
  localparam int          TIMEOUT_NS      = 40_000_000;
  // Op code 3 has no meaning: the block must ignore it.
  localparam logic [1:0]  OP_UNUSED       = 2'd3;
  localparam logic [31:0] VAL_MAX         = 32'h7FFF_FFFF;
  localparam logic [31:0] VAL_MIN         = 32'h8000_0000;

  typedef struct packed {
    logic [1:0]         kind;
    logic signed [31:0] entry;
    logic               from_second;
    logic               last;
  } merge_result_t;

  typedef struct packed {
    logic [1:0]         op;
    logic signed [31:0] value;
    logic               typed;
    logic [1:0]         kind;
  } directed_row_t;

  logic               clk             = 1'b0;
  logic               rst_n           = 1'b0;
  logic               in_valid        = 1'b0;
  logic               in_stall;
  logic [1:0]         in_op           = OP_INS_A;
  logic signed [31:0] in_value        = '0;
  logic               out_valid;
  logic               out_stall       = 1'b0;
  logic [1:0]         out_kind;
  logic signed [31:0] out_entry;
  logic               out_from_second;
  logic               out_last;

  // Shadow copies of the two lists and the results still owed by the block.
  logic signed [31:0] shadow_a [$];
  logic signed [31:0] shadow_b [$];
  merge_result_t      awaited_results [$];

  int mismatches      = 0;
  int results_checked = 0;
  int requests_sent   = 0;
  int merges_sent     = 0;
  int full_drops      = 0;
  bit hold_output     = 1'b0;

  // Directed requests: extremes, ties between and within lists, one-sided and empty merges,
  // and the unused op code. Rows with typed = 1 carry their single result directly.
  directed_row_t directed_rows [20] = '{
    '{OP_MERGE,  32'sd0,        1'b1, KIND_EMPTY},
    '{OP_UNUSED, 32'hFFFF_FFFF, 1'b0, KIND_OK},
    '{OP_INS_B,  VAL_MAX,       1'b1, KIND_OK},
    '{OP_INS_B,  VAL_MIN,       1'b1, KIND_OK},
    '{OP_MERGE,  32'hFFFF_FFFF, 1'b0, KIND_OK},
    '{OP_INS_A,  32'sd0,        1'b1, KIND_OK},
    '{OP_INS_A,  -32'sd1,       1'b1, KIND_OK},
    '{OP_INS_B,  32'sd0,        1'b1, KIND_OK},
    '{OP_INS_A,  32'sd0,        1'b1, KIND_OK},
    '{OP_INS_A,  VAL_MAX,       1'b1, KIND_OK},
    '{OP_INS_A,  VAL_MIN,       1'b1, KIND_OK},
    '{OP_MERGE,  32'sd0,        1'b0, KIND_OK},
    '{OP_INS_B,  32'sd1,        1'b1, KIND_OK},
    '{OP_INS_B,  -32'sd2,       1'b1, KIND_OK},
    '{OP_INS_A,  32'sd5,        1'b1, KIND_OK},
    '{OP_UNUSED, 32'sd5,        1'b0, KIND_OK},
    '{OP_MERGE,  32'sd0,        1'b0, KIND_OK},
    '{OP_INS_A,  32'h5555_5555, 1'b1, KIND_OK},
    '{OP_INS_B,  32'hAAAA_AAAA, 1'b1, KIND_OK},
    '{OP_MERGE,  32'h1234_5678, 1'b0, KIND_OK}
  };

  sorted_insert_and_merge #(
    .LIST_DEPTH  (LIST_DEPTH),
    .VALUE_WIDTH (32)
  ) i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_op           (in_op),
    .in_value        (in_value),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_kind        (out_kind),
    .out_entry       (out_entry),
    .out_from_second (out_from_second),
    .out_last        (out_last)
  );

  always #5 clk = ~clk;

  // Place before the first entry that is not smaller than the new value.
  function automatic int sorted_slot(input logic signed [31:0] list [$],
                                     input logic signed [31:0] value);
    int pos;
    pos = 0;
    while (pos < list.size() && list[pos] < value) pos++;
    return pos;
  endfunction

  // Update the shadow lists for one accepted request and queue the results it owes.
  function automatic void apply_request(input logic [1:0] op, input logic signed [31:0] value);
    int  ia;
    int  ib;
    int  na;
    int  nb;
    bit  take_a;
    logic signed [31:0] pick;
    ia = 0;
    ib = 0;
    na = shadow_a.size();
    nb = shadow_b.size();
    case (op)
      OP_INS_A, OP_INS_B: begin
        if ((op == OP_INS_A ? na : nb) >= LIST_DEPTH) begin
          full_drops++;
          awaited_results.push_back('{KIND_FULL, 32'sd0, 1'b0, 1'b1});
        end else begin
          if (op == OP_INS_A) shadow_a.insert(sorted_slot(shadow_a, value), value);
          else shadow_b.insert(sorted_slot(shadow_b, value), value);
          awaited_results.push_back('{KIND_OK, 32'sd0, 1'b0, 1'b1});
        end
      end
      OP_MERGE: begin
        if (na == 0 && nb == 0) begin
          awaited_results.push_back('{KIND_EMPTY, 32'sd0, 1'b0, 1'b1});
        end
        // On equal values list B goes first, so A wins only when strictly smaller.
        while (ia < na || ib < nb) begin
          take_a = (ia < na) && ((ib >= nb) || (shadow_a[ia] < shadow_b[ib]));
          if (take_a) begin
            pick = shadow_a[ia];
            ia++;
          end else begin
            pick = shadow_b[ib];
            ib++;
          end
          awaited_results.push_back('{KIND_ENTRY, pick, !take_a,
                                      (ia >= na && ib >= nb)});
        end
      end
      default: begin
      end
    endcase
  endfunction

  // Idle lengths: mostly none or short, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [1:0] pick_op();
    int r;
    r = $urandom_range(0, 99);
    if (r < 3) return OP_UNUSED;
    if (r < 18) return OP_MERGE;
    if (r < 59) return OP_INS_A;
    return OP_INS_B;
  endfunction

  // Small values give plenty of ties; extremes check the signed order.
  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(0, 9))
      0, 1, 2: return int'($urandom_range(0, 8)) - 4;
      3: begin
        case ($urandom_range(0, 3))
          0: return VAL_MIN;
          1: return VAL_MAX;
          2: return 32'sd0;
          default: return -32'sd1;
        endcase
      end
      default: return $urandom;
    endcase
  endfunction

  // Offer one request, hold it until accepted, then idle for the given number of cycles.
  task automatic offer_request(input logic [1:0] op, input logic signed [31:0] value,
                               input logic typed, input logic [1:0] typed_kind,
                               input int gap);
    int mark;
    in_valid <= 1'b1;
    in_op    <= op;
    in_value <= value;
    do @(posedge clk); while (in_stall);
    mark = awaited_results.size();
    apply_request(op, value);
    if (typed) begin
      while (awaited_results.size() > mark) void'(awaited_results.pop_back());
      awaited_results.push_back('{typed_kind, 32'sd0, 1'b0, 1'b1});
    end
    if (op != OP_UNUSED) requests_sent++;
    if (op == OP_MERGE) merges_sent++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
      mismatches++;
    end
  endtask

  // Result checker: every accepted result against the oldest one owed.
  always @(posedge clk) begin
    merge_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (awaited_results.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual kind %0d entry %h",
                 $time, out_kind, out_entry);
        mismatches++;
      end else begin
        want = awaited_results.pop_front();
        check_field("kind", 32'(want.kind), 32'(out_kind));
        check_field("entry", want.entry, out_entry);
        check_field("from_second", 32'(want.from_second), 32'(out_from_second));
        check_field("last", 32'(want.last), 32'(out_last));
        results_checked++;
      end
    end
  end

  // Receiver: random stalls, runs without stalls, and a long hold-off on request.
  initial begin
    int stall_len;
    int run_len;
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_output) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_output = 1'b0;
      end else begin
        stall_len = pick_gap();
        run_len   = ($urandom_range(0, 19) == 0) ? $urandom_range(40, 80)
                                                 : $urandom_range(1, 4);
        if (stall_len > 0) begin
          out_stall <= 1'b1;
          repeat (stall_len) @(posedge clk);
        end
        out_stall <= 1'b0;
        repeat (run_len) @(posedge clk);
      end
    end
  end

  // Stimulus: reset, directed table, then random requests with idle gaps.
  initial begin
    int         row;
    int         random_sent;
    int         iter;
    int         no_idle_left;
    int         gap;
    logic [1:0] op;
    random_sent  = 0;
    iter         = 0;
    no_idle_left = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (row = 0; row < $size(directed_rows); row++) begin
      offer_request(directed_rows[row].op, directed_rows[row].value,
                    directed_rows[row].typed, directed_rows[row].kind, pick_gap());
    end

    // Lists fill up early, so most later inserts report a full list.
    while (random_sent < RANDOM_REQUESTS) begin
      if (iter == 40 || iter == 230) begin
        hold_output  = 1'b1;
        no_idle_left = 40;
      end else if (no_idle_left == 0 && $urandom_range(0, 19) == 0) begin
        no_idle_left = $urandom_range(10, 30);
      end
      op  = pick_op();
      gap = (no_idle_left > 0) ? 0 : pick_gap();
      if (no_idle_left > 0) no_idle_left--;
      offer_request(op, pick_value(), 1'b0, KIND_OK, gap);
      if (op != OP_UNUSED) random_sent++;
      iter++;
    end
    in_valid <= 1'b0;

    while (awaited_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Run covered %0d requests including %0d merges; %0d results checked,",
             requests_sent, merges_sent, results_checked);
    $display("with %0d inserts dropped on a full list.", full_drops);
    if (mismatches == 0 && awaited_results.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #(TIMEOUT_NS);
    $display("Timeout with %0d results still owed.", awaited_results.size());
    $display("FAILURE");
    $finish;
  end

endmodule

[filelist.f]
design/sim_pkg.sv
design/sim_cell.sv
design/sim_list.sv
design/sorted_insert_and_merge.sv
dv/testbench.sv
